@@ hdl/imhq_pkg.sv @@
// shared types and constants of the indexed min-heap queue
package imhq_pkg;

    localparam int ID_W      = 8;
    localparam int ID_COUNT  = 256;
    localparam int KEY_W     = 31;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    typedef logic [ID_W-1:0]  vertex_t;
    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DECREASE = 2'd1,
        OP_EXTRACT  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DK_SLOT,
        ST_DK_CHECK,
        ST_UP_START,
        ST_UP_KEY,
        ST_UP_CMP,
        ST_UP_DONE,
        ST_EX_KEY,
        ST_EX_SWAP,
        ST_DN_START,
        ST_DN_KEY,
        ST_DN_CMP,
        ST_DN_DONE,
        ST_FINISH
    } state_t;

endpackage

@@ hdl/imhq_ram.sv @@
// memory with one write port and two registered read ports
module imhq_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [DATA_W-1:0] rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ hdl/indexed_min_heap_queue_unit.sv @@
// indexed binary min-heap with insert, decrease-key and extract-min
//
// channel   direction  words                            handshake
// in        input      opcode, vertex_id, new_key       in_valid / in_stall
// out       output     out_vertex, out_key, status      out_valid / out_stall
//
// one word at a time: a new word is taken only in idle; insert and decrease-key walk the
// entry up, extract walks the new root down; each level the entry moves (at most
// log2(CAPACITY)) is a slot read and a key
// read through the registered memory ports, then one compare and write-back
// heap stores come up undefined; reset clears only the entry count and control
// a finished result waits in the output register while the next word is taken
module indexed_min_heap_queue_unit #(
    parameter int CAPACITY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [imhq_pkg::OP_W-1:0]     opcode,
    input  logic [imhq_pkg::ID_W-1:0]     vertex_id,
    input  logic [imhq_pkg::KEY_W-1:0]    new_key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [imhq_pkg::ID_W-1:0]     out_vertex,
    output logic [imhq_pkg::KEY_W-1:0]    out_key,
    output logic [imhq_pkg::STATUS_W-1:0] status
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = SW + 2;
    localparam int IW = $clog2(imhq_pkg::ID_COUNT);

    imhq_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              out_valid_reg, out_valid_next;

    logic [imhq_pkg::OP_W-1:0] op_reg, op_next;
    imhq_pkg::vertex_t id_reg, id_next;
    imhq_pkg::key_t    key_reg, key_next;
    imhq_pkg::vertex_t vtx_reg, vtx_next;
    imhq_pkg::vertex_t root_reg, root_next;
    imhq_pkg::vertex_t child_l_reg, child_l_next;
    imhq_pkg::vertex_t child_r_reg, child_r_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic              moved_reg, moved_next;
    imhq_pkg::vertex_t res_vertex_reg, res_vertex_next;
    imhq_pkg::key_t    res_key_reg, res_key_next;
    imhq_pkg::status_t res_status_reg, res_status_next;
    imhq_pkg::vertex_t out_vertex_reg, out_vertex_next;
    imhq_pkg::key_t    out_key_reg, out_key_next;
    imhq_pkg::status_t out_status_reg, out_status_next;

    // memory ports
    logic              sv_we;
    logic [SW-1:0]     sv_waddr, sv_raddr_a, sv_raddr_b;
    imhq_pkg::vertex_t sv_wdata, sv_q_a, sv_q_b;
    logic              key_we;
    logic [IW-1:0]     key_waddr, key_raddr_a, key_raddr_b;
    imhq_pkg::key_t    key_wdata, key_q_a, key_q_b;
    logic              pos_we;
    logic [IW-1:0]     pos_waddr, pos_raddr;
    logic [SW-1:0]     pos_wdata, pos_q;

    // datapath
    logic              in_accept;
    logic              out_free;
    logic              heap_full;
    logic              heap_empty;
    logic [SW-1:0]     last_slot;
    logic [SW-1:0]     parent_slot;
    logic [SW-1:0]     grand_slot;
    logic              up_move;
    logic              dk_ok;
    logic [LW-1:0]     count_ext;
    logic [LW-1:0]     left_idx, right_idx;
    logic              left_ok, right_ok;
    logic              take_l, take_r, dn_move;
    imhq_pkg::key_t    best_key;
    logic [SW-1:0]     target_slot;
    imhq_pkg::vertex_t target_vtx;
    logic [LW-1:0]     t_left_idx, t_right_idx;
    logic              t_left_ok;

    assign in_stall   = (state_reg != imhq_pkg::ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign heap_full  = (count_reg >= CW'(CAPACITY));
    assign heap_empty = (count_reg == '0);
    assign last_slot  = SW'(count_reg - CW'(1));

    assign parent_slot = (slot_reg - SW'(1)) >> 1;
    assign grand_slot  = (parent_slot - SW'(1)) >> 1;
    assign up_move     = (key_q_a > key_reg);

    assign dk_ok = (CW'(slot_reg) < count_reg) && (sv_q_a == id_reg) && (key_reg < key_q_a);

    assign count_ext = LW'(count_reg);
    assign left_idx  = (LW'(slot_reg) << 1) + LW'(1);
    assign right_idx = (LW'(slot_reg) << 1) + LW'(2);
    assign left_ok   = (left_idx < count_ext);
    assign right_ok  = (right_idx < count_ext);

    assign take_l      = left_ok && (key_q_a < key_reg);
    assign best_key    = take_l ? key_q_a : key_reg;
    assign take_r      = right_ok && (key_q_b < best_key);
    assign dn_move     = take_l || take_r;
    assign target_slot = take_r ? right_idx[SW-1:0] : left_idx[SW-1:0];
    assign target_vtx  = take_r ? child_r_reg : child_l_reg;
    assign t_left_idx  = (LW'(target_slot) << 1) + LW'(1);
    assign t_right_idx = (LW'(target_slot) << 1) + LW'(2);
    assign t_left_ok   = (t_left_idx < count_ext);

    imhq_ram #(
        .DATA_W (imhq_pkg::ID_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (SW)
    ) u_slot_ram (
        .clk       (clk),
        .wr_en     (sv_we),
        .wr_addr   (sv_waddr),
        .wr_data   (sv_wdata),
        .rd_addr_a (sv_raddr_a),
        .rd_data_a (sv_q_a),
        .rd_addr_b (sv_raddr_b),
        .rd_data_b (sv_q_b)
    );

    imhq_ram #(
        .DATA_W (imhq_pkg::KEY_W),
        .DEPTH  (imhq_pkg::ID_COUNT),
        .ADDR_W (IW)
    ) u_key_ram (
        .clk       (clk),
        .wr_en     (key_we),
        .wr_addr   (key_waddr),
        .wr_data   (key_wdata),
        .rd_addr_a (key_raddr_a),
        .rd_data_a (key_q_a),
        .rd_addr_b (key_raddr_b),
        .rd_data_b (key_q_b)
    );

    imhq_ram #(
        .DATA_W (SW),
        .DEPTH  (imhq_pkg::ID_COUNT),
        .ADDR_W (IW)
    ) u_pos_ram (
        .clk       (clk),
        .wr_en     (pos_we),
        .wr_addr   (pos_waddr),
        .wr_data   (pos_wdata),
        .rd_addr_a (pos_raddr),
        .rd_data_a (pos_q),
        .rd_addr_b (pos_raddr),
        .rd_data_b ()
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imhq_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = imhq_pkg::ST_DISPATCH;
                end
            end
            imhq_pkg::ST_DISPATCH:
            begin
                unique case (imhq_pkg::op_t'(op_reg))
                    imhq_pkg::OP_INSERT:
                    begin
                        state_next = heap_full ? imhq_pkg::ST_FINISH : imhq_pkg::ST_UP_START;
                    end
                    imhq_pkg::OP_DECREASE:
                    begin
                        state_next = imhq_pkg::ST_DK_SLOT;
                    end
                    imhq_pkg::OP_EXTRACT:
                    begin
                        state_next = heap_empty ? imhq_pkg::ST_FINISH : imhq_pkg::ST_EX_KEY;
                    end
                    default:
                    begin
                        state_next = imhq_pkg::ST_FINISH;
                    end
                endcase
            end
            imhq_pkg::ST_DK_SLOT:
            begin
                state_next = imhq_pkg::ST_DK_CHECK;
            end
            imhq_pkg::ST_DK_CHECK:
            begin
                state_next = dk_ok ? imhq_pkg::ST_UP_START : imhq_pkg::ST_FINISH;
            end
            imhq_pkg::ST_UP_START:
            begin
                state_next = (slot_reg == '0) ? imhq_pkg::ST_UP_DONE : imhq_pkg::ST_UP_KEY;
            end
            imhq_pkg::ST_UP_KEY:
            begin
                state_next = imhq_pkg::ST_UP_CMP;
            end
            imhq_pkg::ST_UP_CMP:
            begin
                if (!up_move)
                begin
                    state_next = imhq_pkg::ST_FINISH;
                end
                else if (parent_slot == '0)
                begin
                    state_next = imhq_pkg::ST_UP_DONE;
                end
                else
                begin
                    state_next = imhq_pkg::ST_UP_KEY;
                end
            end
            imhq_pkg::ST_UP_DONE:
            begin
                state_next = imhq_pkg::ST_FINISH;
            end
            imhq_pkg::ST_EX_KEY:
            begin
                state_next = imhq_pkg::ST_EX_SWAP;
            end
            imhq_pkg::ST_EX_SWAP:
            begin
                state_next = imhq_pkg::ST_DN_START;
            end
            imhq_pkg::ST_DN_START:
            begin
                state_next = left_ok ? imhq_pkg::ST_DN_KEY : imhq_pkg::ST_DN_DONE;
            end
            imhq_pkg::ST_DN_KEY:
            begin
                state_next = imhq_pkg::ST_DN_CMP;
            end
            imhq_pkg::ST_DN_CMP:
            begin
                state_next = (dn_move && t_left_ok) ? imhq_pkg::ST_DN_KEY
                                                    : imhq_pkg::ST_DN_DONE;
            end
            imhq_pkg::ST_DN_DONE:
            begin
                state_next = imhq_pkg::ST_FINISH;
            end
            imhq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = imhq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = imhq_pkg::ST_IDLE;
            end
        endcase
    end

    // memory controls
    always_comb
    begin
        sv_we       = 1'b0;
        sv_waddr    = slot_reg;
        sv_wdata    = vtx_reg;
        sv_raddr_a  = '0;
        sv_raddr_b  = '0;
        key_we      = 1'b0;
        key_waddr   = id_reg;
        key_wdata   = key_reg;
        key_raddr_a = id_reg;
        key_raddr_b = id_reg;
        pos_we      = 1'b0;
        pos_waddr   = vtx_reg;
        pos_wdata   = slot_reg;
        pos_raddr   = id_reg;
        unique case (state_reg)
            imhq_pkg::ST_DISPATCH:
            begin
                if ((imhq_pkg::op_t'(op_reg) == imhq_pkg::OP_INSERT) && !heap_full)
                begin
                    key_we = 1'b1;
                end
                if (imhq_pkg::op_t'(op_reg) == imhq_pkg::OP_EXTRACT)
                begin
                    sv_raddr_b = last_slot;
                end
            end
            imhq_pkg::ST_DK_SLOT:
            begin
                sv_raddr_a = pos_q;
            end
            imhq_pkg::ST_DK_CHECK:
            begin
                key_we = dk_ok;
            end
            imhq_pkg::ST_UP_START:
            begin
                sv_raddr_a = parent_slot;
            end
            imhq_pkg::ST_UP_KEY:
            begin
                key_raddr_a = sv_q_a;
            end
            imhq_pkg::ST_UP_CMP:
            begin
                sv_we  = 1'b1;
                pos_we = 1'b1;
                if (up_move)
                begin
                    sv_wdata   = child_l_reg;
                    pos_waddr  = child_l_reg;
                    sv_raddr_a = grand_slot;
                end
            end
            imhq_pkg::ST_UP_DONE:
            begin
                sv_we  = 1'b1;
                pos_we = 1'b1;
            end
            imhq_pkg::ST_EX_KEY:
            begin
                key_raddr_a = sv_q_a;
                key_raddr_b = sv_q_b;
            end
            imhq_pkg::ST_EX_SWAP:
            begin
                sv_we     = 1'b1;
                sv_waddr  = last_slot;
                sv_wdata  = root_reg;
                pos_we    = 1'b1;
                pos_waddr = root_reg;
                pos_wdata = last_slot;
            end
            imhq_pkg::ST_DN_START:
            begin
                sv_raddr_a = left_idx[SW-1:0];
                sv_raddr_b = right_idx[SW-1:0];
            end
            imhq_pkg::ST_DN_KEY:
            begin
                key_raddr_a = sv_q_a;
                key_raddr_b = sv_q_b;
            end
            imhq_pkg::ST_DN_CMP:
            begin
                sv_raddr_a = t_left_idx[SW-1:0];
                sv_raddr_b = t_right_idx[SW-1:0];
                if (dn_move)
                begin
                    sv_we     = 1'b1;
                    sv_wdata  = target_vtx;
                    pos_we    = 1'b1;
                    pos_waddr = target_vtx;
                end
            end
            imhq_pkg::ST_DN_DONE:
            begin
                sv_we = 1'b1;
                // a duplicate id left at the root keeps its position at the old last slot
                pos_we = moved_reg || (vtx_reg != root_reg);
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        op_next         = op_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        vtx_next        = vtx_reg;
        root_next       = root_reg;
        child_l_next    = child_l_reg;
        child_r_next    = child_r_reg;
        slot_next       = slot_reg;
        moved_next      = moved_reg;
        res_vertex_next = res_vertex_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        out_vertex_next = out_vertex_reg;
        out_key_next    = out_key_reg;
        out_status_next = out_status_reg;
        unique case (state_reg)
            imhq_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next  = opcode;
                    id_next  = vertex_id;
                    key_next = new_key;
                end
            end
            imhq_pkg::ST_DISPATCH:
            begin
                res_vertex_next = '0;
                res_key_next    = '0;
                res_status_next = imhq_pkg::STATUS_OK;
                vtx_next        = id_reg;
                unique case (imhq_pkg::op_t'(op_reg))
                    imhq_pkg::OP_INSERT:
                    begin
                        if (heap_full)
                        begin
                            res_status_next = imhq_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            slot_next  = SW'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    imhq_pkg::OP_EXTRACT:
                    begin
                        if (heap_empty)
                        begin
                            res_status_next = imhq_pkg::STATUS_EMPTY;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            imhq_pkg::ST_DK_SLOT:
            begin
                slot_next = pos_q;
            end
            imhq_pkg::ST_UP_KEY:
            begin
                child_l_next = sv_q_a;
            end
            imhq_pkg::ST_UP_CMP:
            begin
                if (up_move)
                begin
                    slot_next = parent_slot;
                end
            end
            imhq_pkg::ST_EX_KEY:
            begin
                root_next = sv_q_a;
                vtx_next  = sv_q_b;
            end
            imhq_pkg::ST_EX_SWAP:
            begin
                res_vertex_next = root_reg;
                res_key_next    = key_q_a;
                key_next        = key_q_b;
                slot_next       = '0;
                moved_next      = 1'b0;
                count_next      = count_reg - CW'(1);
            end
            imhq_pkg::ST_DN_KEY:
            begin
                child_l_next = sv_q_a;
                child_r_next = sv_q_b;
            end
            imhq_pkg::ST_DN_CMP:
            begin
                if (dn_move)
                begin
                    slot_next  = target_slot;
                    moved_next = 1'b1;
                end
            end
            imhq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = res_vertex_reg;
                    out_key_next    = res_key_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imhq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        vtx_reg        <= vtx_next;
        root_reg       <= root_next;
        child_l_reg    <= child_l_next;
        child_r_reg    <= child_r_next;
        slot_reg       <= slot_next;
        moved_reg      <= moved_next;
        res_vertex_reg <= res_vertex_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        out_vertex_reg <= out_vertex_next;
        out_key_reg    <= out_key_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_vertex = out_vertex_reg;
    assign out_key    = out_key_reg;
    assign status     = out_status_reg;

endmodule

@@ sim/indexed_min_heap_queue_unit_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the indexed min-heap queue unit with its own heap predictor
module indexed_min_heap_queue_unit_tb;

    localparam int HEAP_CAP = 256;
    localparam logic [imhq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam imhq_pkg::key_t KEY_MAX = '1;

    typedef struct {
        imhq_pkg::vertex_t vertex;
        imhq_pkg::key_t    key;
        imhq_pkg::status_t code;
    } heap_result_t;

    typedef struct {
        logic [imhq_pkg::OP_W-1:0] op;
        imhq_pkg::vertex_t         id;
        imhq_pkg::key_t            key;
        heap_result_t              result;
    } heap_word_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [imhq_pkg::OP_W-1:0]     opcode = '0;
    logic [imhq_pkg::ID_W-1:0]     vertex_id = '0;
    logic [imhq_pkg::KEY_W-1:0]    new_key = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [imhq_pkg::ID_W-1:0]     out_vertex;
    logic [imhq_pkg::KEY_W-1:0]    out_key;
    logic [imhq_pkg::STATUS_W-1:0] status;

    indexed_min_heap_queue_unit #(
        .CAPACITY(HEAP_CAP)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .vertex_id(vertex_id),
        .new_key(new_key),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_vertex(out_vertex),
        .out_key(out_key),
        .status(status)
    );

    imhq_pkg::vertex_t slot_id [HEAP_CAP];
    imhq_pkg::key_t    id_key [imhq_pkg::ID_COUNT];
    imhq_pkg::vertex_t id_slot [imhq_pkg::ID_COUNT];
    bit                id_written [imhq_pkg::ID_COUNT];
    int unsigned       heap_count = 0;
    imhq_pkg::vertex_t written_ids [$];

    heap_word_t   word_q [$];
    heap_result_t result_q [$];

    heap_word_t   cur_word;
    heap_result_t head_result;
    int unsigned  gap_left = 0;
    int unsigned  stall_left = 0;
    bit           in_taken = 1'b0;
    bit           out_taken = 1'b0;
    bit           in_burst = 1'b0;
    bit           out_burst = 1'b0;
    int unsigned  fail_count = 0;

    function automatic imhq_pkg::key_t slot_key(int unsigned s);
        return id_key[slot_id[s]];
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        imhq_pkg::vertex_t t;
        t = slot_id[a];
        slot_id[a] = slot_id[b];
        slot_id[b] = t;
        id_slot[slot_id[a]] = a[7:0];
        id_slot[slot_id[b]] = b[7:0];
    endfunction

    function automatic void sift_up(int unsigned s);
        int unsigned p;
        while (s > 0)
        begin
            p = (s - 1) / 2;
            if (slot_key(p) > slot_key(s))
            begin
                swap_slots(s, p);
                s = p;
            end
            else
                break;
        end
    endfunction

    function automatic bit id_present(imhq_pkg::vertex_t id);
        return id_written[id] && id_slot[id] < heap_count && slot_id[id_slot[id]] == id;
    endfunction

    function automatic heap_result_t heap_apply(logic [imhq_pkg::OP_W-1:0] op,
                                                imhq_pkg::vertex_t id, imhq_pkg::key_t key);
        heap_result_t   r;
        int unsigned    s;
        int unsigned    best_s;
        int unsigned    l;
        int unsigned    rt;
        imhq_pkg::key_t best;
        r.vertex = '0;
        r.key = '0;
        r.code = imhq_pkg::STATUS_OK;
        case (op)
            imhq_pkg::OP_INSERT:
            begin
                if (heap_count >= HEAP_CAP)
                    r.code = imhq_pkg::STATUS_FULL;
                else
                begin
                    s = heap_count;
                    slot_id[s] = id;
                    id_slot[id] = s[7:0];
                    id_key[id] = key;
                    if (!id_written[id])
                    begin
                        id_written[id] = 1'b1;
                        written_ids.push_back(id);
                    end
                    heap_count++;
                    sift_up(s);
                end
            end
            imhq_pkg::OP_DECREASE:
            begin
                if (id_present(id) && key < id_key[id])
                begin
                    id_key[id] = key;
                    sift_up(id_slot[id]);
                end
            end
            imhq_pkg::OP_EXTRACT:
            begin
                if (heap_count == 0)
                    r.code = imhq_pkg::STATUS_EMPTY;
                else
                begin
                    r.vertex = slot_id[0];
                    r.key = id_key[r.vertex];
                    swap_slots(0, heap_count - 1);
                    heap_count--;
                    s = 0;
                    while (s < heap_count)
                    begin
                        best = slot_key(s);
                        best_s = s;
                        l = 2 * s + 1;
                        rt = 2 * s + 2;
                        if (l < heap_count && slot_key(l) < best)
                        begin
                            best = slot_key(l);
                            best_s = l;
                        end
                        if (rt < heap_count && slot_key(rt) < best)
                            best_s = rt;
                        if (best_s == s)
                            break;
                        swap_slots(s, best_s);
                        s = best_s;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void send_word(logic [imhq_pkg::OP_W-1:0] op, imhq_pkg::vertex_t id,
                                      imhq_pkg::key_t key);
        heap_word_t w;
        w.op = op;
        w.id = id;
        w.key = key;
        w.result = heap_apply(op, id, key);
        word_q.push_back(w);
    endfunction

    function automatic imhq_pkg::key_t pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return imhq_pkg::key_t'($urandom_range(0, 15));
        if (r == 3)
            return ($urandom_range(0, 1) != 0) ? KEY_MAX : imhq_pkg::key_t'(0);
        return imhq_pkg::key_t'($urandom);
    endfunction

    function automatic imhq_pkg::vertex_t pick_free_id();
        imhq_pkg::vertex_t id;
        id = imhq_pkg::vertex_t'($urandom);
        for (int i = 0; i < imhq_pkg::ID_COUNT; i++)
        begin
            if (!id_present(id))
                return id;
            id++;
        end
        return id;
    endfunction

    function automatic void random_word(int unsigned insert_pct);
        int unsigned       r;
        imhq_pkg::vertex_t id;
        imhq_pkg::key_t    cur;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
        begin
            if ($urandom_range(0, 29) == 0)
                id = imhq_pkg::vertex_t'($urandom);
            else
                id = pick_free_id();
            send_word(imhq_pkg::OP_INSERT, id, pick_key());
        end
        else if (r < insert_pct + (100 - insert_pct) / 3 && written_ids.size() > 0)
        begin
            // mostly ids in the heap, some that have left it
            if (heap_count > 0 && $urandom_range(0, 4) != 0)
                id = slot_id[$urandom_range(0, heap_count - 1)];
            else
                id = written_ids[$urandom_range(0, written_ids.size() - 1)];
            cur = id_key[id];
            if (cur == 0 || $urandom_range(0, 5) == 0)
                send_word(imhq_pkg::OP_DECREASE, id, pick_key());
            else if ($urandom_range(0, 5) == 0)
                send_word(imhq_pkg::OP_DECREASE, id, cur);
            else
                send_word(imhq_pkg::OP_DECREASE, id,
                          imhq_pkg::key_t'($urandom_range(0, cur - 1)));
        end
        else if (r >= 98)
            send_word(OP_UNUSED, imhq_pkg::vertex_t'($urandom), imhq_pkg::key_t'($urandom));
        else
            send_word(imhq_pkg::OP_EXTRACT, imhq_pkg::vertex_t'($urandom),
                      imhq_pkg::key_t'($urandom));
    endfunction

    task automatic wait_drained();
        while (word_q.size() != 0 || result_q.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    initial
    begin
        forever #2 clk = ~clk;
    end

    // input side
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
            result_q.push_back(cur_word.result);
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && !in_taken))
        begin
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (word_q.size() > 0)
        begin
            cur_word = word_q.pop_front();
            opcode <= cur_word.op;
            vertex_id <= cur_word.id;
            new_key <= cur_word.key;
            in_valid <= 1'b1;
            if ($urandom_range(0, 49) == 0)
                in_burst = !in_burst;
            gap_left = in_burst ? 0 : $urandom_range(0, 3);
        end
        else
            in_valid <= 1'b0;
    end

    // output side
    always @(posedge clk)
    begin
        out_taken <= out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected word: expected none, actual vertex %h key %h status %h",
                         $time, out_vertex, out_key, status);
            end
            else
            begin
                head_result = result_q.pop_front();
                if (out_vertex !== head_result.vertex)
                begin
                    fail_count++;
                    $display("%0t: out_vertex mismatch: expected %h, actual %h",
                             $time, head_result.vertex, out_vertex);
                end
                if (out_key !== head_result.key)
                begin
                    fail_count++;
                    $display("%0t: out_key mismatch: expected %h, actual %h",
                             $time, head_result.key, out_key);
                end
                if (status !== head_result.code)
                begin
                    fail_count++;
                    $display("%0t: status mismatch: expected %h, actual %h",
                             $time, head_result.code, status);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_taken)
        begin
            if ($urandom_range(0, 49) == 0)
                out_burst = !out_burst;
            stall_left = out_burst ? 0 : $urandom_range(0, 3);
        end
        if (stall_left > 0 && out_valid)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty heap, unused opcode, key extremes, ties and ignored decreases
        send_word(imhq_pkg::OP_EXTRACT, 8'hFF, KEY_MAX);
        send_word(OP_UNUSED, 8'hFF, KEY_MAX);
        send_word(imhq_pkg::OP_INSERT, 8'h00, KEY_MAX);
        send_word(imhq_pkg::OP_INSERT, 8'hFF, '0);
        send_word(imhq_pkg::OP_INSERT, 8'h5A, 31'h2AAA_AAAA);
        send_word(imhq_pkg::OP_INSERT, 8'hA5, 31'h5555_5555);
        send_word(imhq_pkg::OP_INSERT, 8'h01, 31'd7);
        send_word(imhq_pkg::OP_INSERT, 8'h02, 31'd7);
        send_word(imhq_pkg::OP_INSERT, 8'h03, 31'd7);
        send_word(imhq_pkg::OP_DECREASE, 8'h5A, 31'd3);
        send_word(imhq_pkg::OP_DECREASE, 8'hA5, KEY_MAX);
        send_word(imhq_pkg::OP_DECREASE, 8'h01, 31'd7);
        send_word(imhq_pkg::OP_DECREASE, 8'h03, '0);
        send_word(imhq_pkg::OP_EXTRACT, 8'h00, '0);
        send_word(imhq_pkg::OP_EXTRACT, 8'h00, '0);
        send_word(imhq_pkg::OP_DECREASE, 8'hFF, '0);
        send_word(imhq_pkg::OP_INSERT, 8'h02, 31'd100);
        repeat (8) send_word(imhq_pkg::OP_EXTRACT, imhq_pkg::vertex_t'($urandom),
                             imhq_pkg::key_t'($urandom));

        // let the block run dry before the random part
        wait_drained();
        repeat (10) @(posedge clk);

        for (int p = 0; p < 6; p++)
            for (int i = 0; i < 40; i++)
                random_word((p % 2 != 0) ? 35 : 60);

        // drain, fill to capacity, work around full, drain again
        while (heap_count > 0)
            send_word(imhq_pkg::OP_EXTRACT, imhq_pkg::vertex_t'($urandom),
                      imhq_pkg::key_t'($urandom));
        while (heap_count < HEAP_CAP)
            random_word(85);
        repeat (4) send_word(imhq_pkg::OP_INSERT, imhq_pkg::vertex_t'($urandom), pick_key());
        repeat (40) random_word(50);
        while (heap_count > 0)
            random_word(10);
        repeat (2) send_word(imhq_pkg::OP_EXTRACT, imhq_pkg::vertex_t'($urandom),
                             imhq_pkg::key_t'($urandom));

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
